// ----- rtl/ip_transport_checksum_offload_assert.svh -----
// Assertion macros for the IPv4 transport checksum offload block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef IP_TRANSPORT_CHECKSUM_OFFLOAD_ASSERT_SVH
`define IP_TRANSPORT_CHECKSUM_OFFLOAD_ASSERT_SVH

// same-cycle implication
`define ITCO_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITCO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/itco_pkg.sv -----
// Shared types and constants for the IPv4 transport checksum offload block.
// No dependencies.
`default_nettype none

package itco_pkg;

  localparam int unsigned POS_W      = 17;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned HDR_W      = 6;
  localparam int unsigned OFF_W      = 7;
  localparam int unsigned TERM_W     = 18;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned CSUM_W     = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [7:0] PROTO_IP   = 8'd0;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [OFF_W-1:0] IP_CSUM_OFF   = 7'd10;
  localparam logic [OFF_W-1:0] TCP_CSUM_REL  = 7'd16;
  localparam logic [OFF_W-1:0] UDP_CSUM_REL  = 7'd6;
  localparam logic [OFF_W-1:0] ICMP_CSUM_REL = 7'd2;

  localparam logic [POS_W-1:0] PSEUDO_FIRST = 17'd12;
  localparam logic [POS_W-1:0] PSEUDO_LAST  = 17'd19;

  localparam logic [3:0] IP_VERSION = 4'd4;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_ZERO_LEN,
    STATUS_BAD_VER,
    STATUS_BAD_PROTO
  } status_e;

  typedef struct packed {
    logic              first;
    logic              last;
    logic [TERM_W-1:0] term;
    status_e           status;
    logic [OFF_W-1:0]  offset;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/itco_if.sv -----
// Valid/ready channel interfaces for packet bytes in and checksum results out.
// No dependencies.
`default_nettype none

interface itco_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic [7:0] protocol_select;
  logic [15:0] segment_length;

  modport source (output valid, data_byte, last_byte, protocol_select, segment_length,
                  input ready);
  modport sink (input valid, data_byte, last_byte, protocol_select, segment_length,
                output ready);
endinterface

interface itco_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum_value;
  logic [6:0]  checksum_offset;
  logic [1:0]  status;

  modport source (output valid, checksum_value, checksum_offset, status, input ready);
  modport sink (input valid, checksum_value, checksum_offset, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/itco_fifo.sv -----
// Short flop queue of classified beats between front and back.
// Depends on itco_pkg.
`default_nettype none

module itco_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  itco_pkg::entry_t     push_entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output itco_pkg::entry_t     head_o,
  output logic                 empty_o
);

  itco_pkg::entry_t mem_q [itco_pkg::FIFO_DEPTH];
  logic [itco_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [itco_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [itco_pkg::FIFO_CNT_W-1:0] count_q, count_d;

  localparam logic [itco_pkg::FIFO_PTR_W-1:0] PtrLast =
    itco_pkg::FIFO_PTR_W'(itco_pkg::FIFO_DEPTH - 1);
  localparam logic [itco_pkg::FIFO_CNT_W-1:0] CntFull =
    itco_pkg::FIFO_CNT_W'(itco_pkg::FIFO_DEPTH);

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itco_front.sv -----
// Front end: takes packet beats, tracks position and header fields, and
// turns each beat into a checksum term plus result status. Depends on itco_pkg.
`default_nettype none

module itco_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  itco_in_if.sink          in_i,
  output logic             push_o,
  output itco_pkg::entry_t entry_o,
  input  wire logic        full_i
);

  logic [itco_pkg::POS_W-1:0] pos_q, pos_d;
  logic [itco_pkg::HDR_W-1:0] hdr_q, hdr_d;
  logic                       vgood_q, vgood_d;
  logic [7:0]                 proto_q, proto_d;
  logic [itco_pkg::LEN_W-1:0] len_q, len_d;

  logic                       first;
  logic                       is_ip, is_icmp, is_tcp, is_udp, is_l4, known;
  logic [itco_pkg::OFF_W-1:0] off;
  logic [itco_pkg::POS_W-1:0] hdr_ext, off_ext, seg_end;
  logic [15:0]                bval;
  logic                       ip_hit, seg_hit, pse_hit;
  logic [itco_pkg::TERM_W-1:0] term;
  itco_pkg::status_e          status;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign first      = (pos_q == '0);

  always_comb begin
    proto_d = first ? in_i.protocol_select : proto_q;
    len_d   = first ? in_i.segment_length : len_q;
    hdr_d   = first ? {in_i.data_byte[3:0], 2'b00} : hdr_q;
    vgood_d = first ? (in_i.data_byte[7:4] == itco_pkg::IP_VERSION) : vgood_q;

    is_ip   = (proto_d == itco_pkg::PROTO_IP);
    is_icmp = (proto_d == itco_pkg::PROTO_ICMP);
    is_tcp  = (proto_d == itco_pkg::PROTO_TCP);
    is_udp  = (proto_d == itco_pkg::PROTO_UDP);
    is_l4   = is_tcp || is_udp;
    known   = is_ip || is_icmp || is_l4;

    priority if (is_tcp) begin
      off = {1'b0, hdr_d} + itco_pkg::TCP_CSUM_REL;
    end else if (is_udp) begin
      off = {1'b0, hdr_d} + itco_pkg::UDP_CSUM_REL;
    end else if (is_icmp) begin
      off = {1'b0, hdr_d} + itco_pkg::ICMP_CSUM_REL;
    end else begin
      off = itco_pkg::IP_CSUM_OFF;
    end

    hdr_ext = {{(itco_pkg::POS_W - itco_pkg::HDR_W){1'b0}}, hdr_d};
    off_ext = {{(itco_pkg::POS_W - itco_pkg::OFF_W){1'b0}}, off};
    seg_end = hdr_ext + {{(itco_pkg::POS_W - itco_pkg::LEN_W){1'b0}}, len_d};
    bval    = pos_q[0] ? {8'h00, in_i.data_byte} : {in_i.data_byte, 8'h00};

    ip_hit  = is_ip && (pos_q < hdr_ext) && (pos_q != itco_pkg::POS_W'(10))
              && (pos_q != itco_pkg::POS_W'(11));
    seg_hit = (is_icmp || is_l4) && (pos_q >= hdr_ext) && (pos_q < seg_end)
              && (pos_q != off_ext) && (pos_q != off_ext + 1'b1);
    pse_hit = is_l4 && (pos_q >= itco_pkg::PSEUDO_FIRST)
              && (pos_q <= itco_pkg::PSEUDO_LAST);

    term = (ip_hit  ? {2'b00, bval} : '0)
         + (seg_hit ? {2'b00, bval} : '0)
         + (pse_hit ? {2'b00, bval} : '0)
         + ((first && is_l4) ? ({10'd0, proto_d} + {2'b00, len_d}) : '0);

    priority if ((len_d == '0) && !is_ip) begin
      status = itco_pkg::STATUS_ZERO_LEN;
    end else if (!vgood_d) begin
      status = itco_pkg::STATUS_BAD_VER;
    end else if (!known) begin
      status = itco_pkg::STATUS_BAD_PROTO;
    end else begin
      status = itco_pkg::STATUS_OK;
    end

    entry_o.first  = first;
    entry_o.last   = in_i.last_byte;
    entry_o.term   = term;
    entry_o.status = status;
    entry_o.offset = (status == itco_pkg::STATUS_OK) ? off : '0;

    pos_d = pos_q;
    if (push_o) begin
      if (in_i.last_byte) begin
        pos_d = '0;
      end else if (pos_q != itco_pkg::POS_MAX) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hdr_q   <= '0;
      vgood_q <= 1'b0;
      proto_q <= '0;
      len_q   <= '0;
    end else if (push_o) begin
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      vgood_q <= vgood_d;
      proto_q <= proto_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itco_back.sv -----
// Back end: accumulates queued terms, then folds and complements the sum
// into a registered result beat, zero on error status. Depends on itco_pkg.
`default_nettype none

module itco_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  itco_pkg::entry_t head_i,
  input  wire logic        avail_i,
  output logic             pop_o,
  itco_out_if.source       out_o
);

  logic [itco_pkg::SUM_W-1:0]  acc_q, acc_d;
  logic                        fin_valid_q;
  logic [itco_pkg::SUM_W-1:0]  fin_sum_q;
  itco_pkg::status_e           fin_status_q;
  logic [itco_pkg::OFF_W-1:0]  fin_offset_q;

  logic                        out_valid_q;
  logic [itco_pkg::CSUM_W-1:0] out_value_q;
  logic [itco_pkg::OFF_W-1:0]  out_offset_q;
  itco_pkg::status_e           out_status_q;

  logic                        fin_move;
  logic [itco_pkg::CSUM_W:0]   fold1;
  logic [itco_pkg::CSUM_W-1:0] fold2;

  assign fin_move = fin_valid_q && (!out_valid_q || out_o.ready);
  assign pop_o    = avail_i && (!head_i.last || !fin_valid_q || fin_move);

  always_comb begin
    acc_d = head_i.first
          ? {{(itco_pkg::SUM_W - itco_pkg::TERM_W){1'b0}}, head_i.term}
          : acc_q + {{(itco_pkg::SUM_W - itco_pkg::TERM_W){1'b0}}, head_i.term};
    fold1 = {1'b0, fin_sum_q[31:16]} + {1'b0, fin_sum_q[15:0]};
    fold2 = fold1[itco_pkg::CSUM_W-1:0] + {{(itco_pkg::CSUM_W - 1){1'b0}}, fold1[16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && head_i.last) begin
        fin_valid_q <= 1'b1;
      end else if (fin_move) begin
        fin_valid_q <= 1'b0;
      end
      if (fin_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      acc_q <= acc_d;
    end
    if (pop_o && head_i.last) begin
      fin_sum_q    <= acc_d;
      fin_status_q <= head_i.status;
      fin_offset_q <= head_i.offset;
    end
    if (fin_move) begin
      out_value_q  <= (fin_status_q == itco_pkg::STATUS_OK) ? ~fold2 : '0;
      out_offset_q <= fin_offset_q;
      out_status_q <= fin_status_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.checksum_value  = out_value_q;
  assign out_o.checksum_offset = out_offset_q;
  assign out_o.status          = out_status_q;

endmodule

`default_nettype wire

// ----- rtl/ip_transport_checksum_offload.sv -----
// Top level of the IPv4 transport checksum offload block.
// Depends on itco_pkg, itco_if, itco_front, itco_fifo, itco_back and the assert header.
`default_nettype none

// Packet bytes enter one beat per cycle, starting at the IPv4 header; the
// protocol select and segment length are sampled with the first beat. A result
// beat (checksum, its byte offset in the packet, status) goes through a final-sum
// register and the output register after the beat marked last leaves the queue, once
// the output is free. Sustained rate is one beat per clock: the front classifies
// a beat combinationally and the back does one accumulator add per cycle, with a
// four-entry queue between them, so a stalled output blocks the input only when full.
`include "ip_transport_checksum_offload_assert.svh"

module ip_transport_checksum_offload (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itco_in_if.sink    in_i,
  itco_out_if.source out_o
);

  logic             push;
  logic             fifo_full;
  logic             fifo_empty;
  logic             pop;
  itco_pkg::entry_t push_entry;
  itco_pkg::entry_t head;

  itco_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (push),
    .entry_o (push_entry),
    .full_i  (fifo_full)
  );

  itco_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (fifo_empty)
  );

  itco_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .avail_i (!fifo_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  `ITCO_ASSERT_IMPL(a_no_overflow, push, !fifo_full, "queue push while full")
  `ITCO_ASSERT_IMPL(a_no_underflow, pop, !fifo_empty, "queue pop while empty")
  `ITCO_ASSERT_IMPL(a_err_no_offset, push && (push_entry.status != itco_pkg::STATUS_OK),
                    push_entry.offset == '0, "error beat carries an offset")
  `ITCO_ASSERT_NEXT(a_last_rearms, in_i.valid && in_i.ready && in_i.last_byte,
                    u_front.first, "front did not rearm after last beat")

endmodule

`default_nettype wire

// ----- verif/tb_ip_transport_checksum_offload.sv -----
`timescale 1ns / 100ps
// Testbench for ip_transport_checksum_offload: streams IPv4 packets a byte per beat
// and checks every result beat against an in-bench checksum predictor.
// Depends on itco_pkg, itco_if and the block's RTL.

module tb_ip_transport_checksum_offload;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  protocol_select;
    logic [15:0] segment_length;
  } pkt_beat_t;

  typedef struct packed {
    logic [itco_pkg::CSUM_W-1:0] value;
    logic [itco_pkg::OFF_W-1:0]  offset;
    itco_pkg::status_e           status;
  } csum_result_t;

  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned PHASE_BEATS = 90;
  localparam int unsigned PHASE_PKTS  = 2;
  localparam int unsigned SRC_IDLE[4]  = '{0, 75, 0, 11};
  localparam int unsigned SINK_STALL[4] = '{0, 0, 75, 11};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  itco_in_if  in_if ();
  itco_out_if out_if ();

  ip_transport_checksum_offload uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pkt_beat_t    pending_beats[$];
  csum_result_t expected_csums[$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          sink_hold;
  bit          hold_start;
  bit          in_beat;
  int unsigned errors;
  int unsigned beats_queued;
  int unsigned packets_queued;
  int unsigned results_checked;
  int unsigned status_count[4];

  // predictor state
  logic [itco_pkg::POS_W-1:0] pos_q     = '0;
  logic [itco_pkg::SUM_W-1:0] acc_q     = '0;
  logic [itco_pkg::HDR_W-1:0] hdr_len_q = '0;
  logic                       ver_ok_q  = 1'b0;
  logic [7:0]                 proto_q   = '0;
  logic [itco_pkg::LEN_W-1:0] len_q     = '0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [15:0] place_byte(input logic odd_pos, input logic [7:0] d);
    return odd_pos ? {8'h00, d} : {d, 8'h00};
  endfunction

  function automatic logic [7:0] pick_proto(input bit known_only);
    case ($urandom_range(known_only ? 3 : 4))
      0: return itco_pkg::PROTO_IP;
      1: return itco_pkg::PROTO_ICMP;
      2: return itco_pkg::PROTO_TCP;
      3: return itco_pkg::PROTO_UDP;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic absorb_beat(input pkt_beat_t b);
    int unsigned  p;
    int unsigned  hdr;
    int unsigned  off;
    int unsigned  s;
    csum_result_t r;
    if (pos_q == '0) begin
      proto_q   = b.protocol_select;
      len_q     = b.segment_length;
      ver_ok_q  = (b.data_byte[7:4] == itco_pkg::IP_VERSION);
      hdr_len_q = {b.data_byte[3:0], 2'b00};
      acc_q     = '0;
      if (proto_q == itco_pkg::PROTO_TCP || proto_q == itco_pkg::PROTO_UDP) begin
        acc_q = 32'(proto_q) + 32'(len_q);
      end
    end
    p   = pos_q;
    hdr = hdr_len_q;
    case (proto_q)
      itco_pkg::PROTO_TCP:  off = hdr + itco_pkg::TCP_CSUM_REL;
      itco_pkg::PROTO_UDP:  off = hdr + itco_pkg::UDP_CSUM_REL;
      itco_pkg::PROTO_ICMP: off = hdr + itco_pkg::ICMP_CSUM_REL;
      default:              off = itco_pkg::IP_CSUM_OFF;
    endcase
    if (proto_q == itco_pkg::PROTO_IP) begin
      if (p < hdr && p != itco_pkg::IP_CSUM_OFF && p != itco_pkg::IP_CSUM_OFF + 1) begin
        acc_q += place_byte(pos_q[0], b.data_byte);
      end
    end else if (proto_q == itco_pkg::PROTO_ICMP || proto_q == itco_pkg::PROTO_TCP ||
                 proto_q == itco_pkg::PROTO_UDP) begin
      if (p >= hdr && p < hdr + len_q && p != off && p != off + 1) begin
        acc_q += place_byte(pos_q[0], b.data_byte);
      end
      // pseudo-header addresses, summed even where they overlap the segment
      if (proto_q != itco_pkg::PROTO_ICMP && p >= itco_pkg::PSEUDO_FIRST &&
          p <= itco_pkg::PSEUDO_LAST) begin
        acc_q += place_byte(pos_q[0], b.data_byte);
      end
    end
    if (pos_q != itco_pkg::POS_MAX) pos_q++;
    if (b.last_byte) begin
      r = '0;
      if (len_q == '0 && proto_q != itco_pkg::PROTO_IP) begin
        r.status = itco_pkg::STATUS_ZERO_LEN;
      end else if (!ver_ok_q) begin
        r.status = itco_pkg::STATUS_BAD_VER;
      end else if (!(proto_q inside {itco_pkg::PROTO_IP, itco_pkg::PROTO_ICMP,
                                     itco_pkg::PROTO_TCP, itco_pkg::PROTO_UDP})) begin
        r.status = itco_pkg::STATUS_BAD_PROTO;
      end else begin
        s = acc_q;
        while (s >> 16) s = (s >> 16) + (s & 32'hFFFF);
        r.status = itco_pkg::STATUS_OK;
        r.value  = ~s[15:0];
        r.offset = off[itco_pkg::OFF_W-1:0];
      end
      expected_csums.push_back(r);
      pos_q = '0;
      acc_q = '0;
    end
  endtask

  task automatic push_beat(input logic [7:0] d, input logic last, input logic [7:0] proto,
                           input logic [15:0] seglen);
    pending_beats.push_back({d, last, proto, seglen});
    beats_queued++;
    if (last) packets_queued++;
  endtask

  // tidy packets are well formed IPv4, at times truncated; the rest are malformed noise
  task automatic queue_packet(input bit tidy);
    logic [7:0]  proto;
    logic [15:0] seglen;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    int unsigned n_beats;
    proto = pick_proto(tidy);
    ver   = (tidy || $urandom_range(1) == 1) ? itco_pkg::IP_VERSION : 4'($urandom);
    if (tidy) begin
      ihl    = ($urandom_range(3) != 0) ? 4'd5 : 4'($urandom_range(6, 15));
      seglen = 16'($urandom_range(4, 40));
    end else begin
      ihl = 4'($urandom);
      case ($urandom_range(3))
        0:       seglen = '0;
        1:       seglen = 16'($urandom);
        default: seglen = 16'($urandom_range(1, 40));
      endcase
    end
    if (!tidy) n_beats = $urandom_range(1, 40);
    else if (proto == itco_pkg::PROTO_IP) n_beats = ihl * 4;
    else n_beats = ihl * 4 + seglen;
    if (tidy && $urandom_range(7) == 0) n_beats = $urandom_range(1, n_beats + 6);
    for (int unsigned i = 0; i < n_beats; i++) begin
      if (i == 0) push_beat({ver, ihl}, n_beats == 1, proto, seglen);
      else push_beat(8'($urandom), i == n_beats - 1, 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || expected_csums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // input side: take accepted beats and predict
  always @(posedge clk_i) begin
    in_beat = 1'b0;
    if (rst_ni && in_if.valid && in_if.ready) begin
      in_beat = 1'b1;
      absorb_beat(pending_beats.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid           <= 1'b0;
      in_if.data_byte       <= '0;
      in_if.last_byte       <= 1'b0;
      in_if.protocol_select <= '0;
      in_if.segment_length  <= '0;
    end else if (in_if.valid && !in_beat) begin
      // beat still on offer: hold it
    end else if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
      in_if.valid <= 1'b1;
      {in_if.data_byte, in_if.last_byte, in_if.protocol_select, in_if.segment_length}
        <= pending_beats[0];
    end else begin
      in_if.valid <= 1'b0;
      {in_if.data_byte, in_if.last_byte, in_if.protocol_select, in_if.segment_length}
        <= 33'({$urandom, $urandom});
    end
  end

  // output side
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= !sink_hold && $urandom_range(99) >= sink_stall_pct;
  end

  always @(posedge clk_i) begin : result_check
    csum_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_csums.size() == 0) begin
        errors++;
        $error("unexpected result beat: checksum_value %h checksum_offset %0d status %0d",
               out_if.checksum_value, out_if.checksum_offset, out_if.status);
      end else begin
        want = expected_csums.pop_front();
        results_checked++;
        status_count[want.status]++;
        if (out_if.checksum_value !== want.value) begin
          errors++;
          $error("checksum_value: expected %h, got %h", want.value, out_if.checksum_value);
        end
        if (out_if.checksum_offset !== want.offset) begin
          errors++;
          $error("checksum_offset: expected %0d, got %0d", want.offset, out_if.checksum_offset);
        end
        if (out_if.status !== want.status) begin
          errors++;
          $error("status: expected %0d, got %0d", want.status, out_if.status);
        end
      end
    end
  end

  initial begin
    sink_hold = 1'b0;
    wait (hold_start);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned beats0;
    int unsigned pkts0;
    int unsigned rand_beats;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: status precedence and extremes of the fields
    push_beat(8'h45, 1'b1, itco_pkg::PROTO_TCP, 16'h0000);
    push_beat(8'h65, 1'b1, itco_pkg::PROTO_IP, 16'h0000);
    push_beat(8'h45, 1'b1, 8'hFF, 16'hFFFF);
    push_beat(8'h00, 1'b1, itco_pkg::PROTO_UDP, 16'h0000);
    push_beat(8'h4F, 1'b1, itco_pkg::PROTO_IP, 16'hFFFF);
    // ICMP with zero header length: odd trailing byte, then a byte past the span
    push_beat(8'h40, 1'b0, itco_pkg::PROTO_ICMP, 16'd5);
    for (int unsigned i = 1; i < 6; i++) push_beat(8'hFF, i == 5, 8'h00, 16'h0000);
    // UDP with a short header: pseudo-header overlaps the segment, packet truncated
    push_beat(8'h43, 1'b0, itco_pkg::PROTO_UDP, 16'hFFFF);
    for (int unsigned i = 1; i < 14; i++) push_beat(8'hFF, i == 13, 8'hFF, 16'hFFFF);
    wait_drained();

    rand_beats = 0;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = SRC_IDLE[ph];
      sink_stall_pct = SINK_STALL[ph];
      beats0 = beats_queued;
      pkts0  = packets_queued;
      while (beats_queued - beats0 < PHASE_BEATS || packets_queued - pkts0 < PHASE_PKTS) begin
        queue_packet($urandom_range(9) < 7);
      end
      rand_beats += beats_queued - beats0;
      wait_drained();
    end

    // long output stall while the sender keeps offering
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_start     = 1'b1;
    for (int i = 0; i < 30; i++) begin
      push_beat({itco_pkg::IP_VERSION, 4'($urandom)}, 1'b1, pick_proto(1'b0), 16'($urandom));
    end
    for (int i = 0; i < 2; i++) queue_packet(1'b1);
    wait_drained();

    $display("checked %0d results over %0d packets and %0d beats, %0d of them in random packets",
             results_checked, packets_queued, beats_queued, rand_beats);
    $display("result mix ok/zero-length/bad-version/bad-protocol: %0d/%0d/%0d/%0d",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
